// ===== rtl/mavlink_v1_frame_receiver_assert.svh =====
// ============================================================================
// MAVLink v1 frame receiver assertion macros
// Shorthand for the concurrent checks written at the end of the top level.
// ============================================================================
`ifndef MAVLINK_V1_FRAME_RECEIVER_ASSERT_SVH
`define MAVLINK_V1_FRAME_RECEIVER_ASSERT_SVH

// The condition must never hold while out of reset.
`define MVR_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

// The antecedent implies the consequent in the same cycle.
`define MVR_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The antecedent implies the consequent in the next cycle.
`define MVR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/mvr_pkg.sv =====
// ============================================================================
// MAVLink v1 frame receiver package
// Shared payload types, constants and the X.25 CRC byte update.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package mvr_pkg;

    localparam int unsigned HDR_BYTES = 5;
    localparam int unsigned TBL_AW    = 8;
    localparam int unsigned TBL_DEPTH = 1 << TBL_AW;

    localparam logic [7:0]  START_BYTE_RESET = 8'hFE;
    localparam logic [15:0] CRC_INIT         = 16'hFFFF;

    localparam logic REQ_RX_BYTE  = 1'b0;
    localparam logic REQ_TABLE_WR = 1'b1;

    typedef enum logic [3:0] {
        PH_SEARCH  = 4'b0001,
        PH_HEADER  = 4'b0010,
        PH_PAYLOAD = 4'b0100,
        PH_CRC     = 4'b1000
    } phase_t;

    typedef struct packed {
        logic       req_type;
        logic [7:0] rx_byte;
        logic [7:0] table_index;
    } req_payload_t;

    typedef struct packed {
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic [7:0] payload_index;
        logic       frame_done;
        logic       crc_ok;
        logic [7:0] msg_length;
        logic [7:0] msg_seq;
        logic [7:0] msg_sys_id;
        logic [7:0] msg_comp_id;
        logic [7:0] msg_id;
    } res_payload_t;

    typedef logic [7:0] cfg_payload_t;

    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
        logic [7:0] t;
        t = b ^ crc[7:0];
        t = t ^ {t[3:0], 4'b0000};
        return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000}
            ^ {12'h000, t[7:4]};
    endfunction

endpackage

`default_nettype wire

// ===== rtl/mvr_stream_if.sv =====
// ============================================================================
// MAVLink v1 frame receiver stream interface
// A valid/ready channel carrying one payload of a chosen type per request.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

interface mvr_stream_if #(
    parameter type payload_t = logic [7:0]
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/mvr_extra_table.sv =====
// ============================================================================
// MAVLink v1 CRC extra table
// 256-entry synchronous memory with per-entry valid bits and write forwarding.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module mvr_extra_table (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      wr_en,
    input  wire logic [mvr_pkg::TBL_AW-1:0] wr_addr,
    input  wire logic [7:0]                wr_data,
    input  wire logic [mvr_pkg::TBL_AW-1:0] rd_addr,
    output logic      [7:0]                rd_data
);
    import mvr_pkg::*;

    logic [7:0]           mem [TBL_DEPTH];
    logic [TBL_DEPTH-1:0] valid_reg;
    logic [7:0]           mem_rd_reg;
    logic                 vld_rd_reg;
    logic                 fwd_hit_reg;
    logic [7:0]           fwd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        mem_rd_reg   <= mem[rd_addr];
        fwd_data_reg <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            vld_rd_reg  <= 1'b0;
            fwd_hit_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            vld_rd_reg  <= valid_reg[rd_addr];
            fwd_hit_reg <= wr_en && (wr_addr == rd_addr);
        end
    end

    // An entry never written reads as zero; a write in the read cycle wins.
    assign rd_data = fwd_hit_reg ? fwd_data_reg : (vld_rd_reg ? mem_rd_reg : 8'h00);

endmodule

`default_nettype wire

// ===== rtl/mavlink_v1_frame_receiver.sv =====
// ============================================================================
// MAVLink v1 frame receiver
// Parses start byte, header, payload and X.25 CRC of received serial bytes.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

// One request is accepted per clock unless a held result stalls the request side,
// with a single output register between the request and result sides. The CRC extra
// table lives in a 256-entry memory whose entry for the current message id is
// read every cycle, so the final CRC byte finds it ready without extra latency.
module mavlink_v1_frame_receiver (
    input  wire logic clk,
    input  wire logic rst_n,
    mvr_stream_if.sink   req,
    mvr_stream_if.source res,
    mvr_stream_if.sink   cfg
);
    import mvr_pkg::*;

    logic [7:0]   start_byte_reg;
    phase_t       phase_reg, phase_next;
    logic [7:0]   count_reg, count_next;
    logic [7:0]   len_reg, len_next;
    logic [7:0]   seq_reg, seq_next;
    logic [7:0]   sys_reg, sys_next;
    logic [7:0]   comp_reg, comp_next;
    logic [7:0]   msgid_reg, msgid_next;
    logic [15:0]  crc_reg, crc_next;
    logic [7:0]   crc_low_reg, crc_low_next;
    logic         res_valid_reg;
    res_payload_t res_payload_reg, res_payload_next;

    logic         accept;
    logic         is_rx;
    logic [7:0]   b;
    logic [7:0]   extra;
    logic [15:0]  crc_upd;
    logic [15:0]  crc_fin;
    logic [8:0]   count_inc;

    assign req.ready = !res_valid_reg || res.ready;
    assign cfg.ready = 1'b1;
    assign accept    = req.valid && req.ready;
    assign is_rx     = (req.payload.req_type == REQ_RX_BYTE);
    assign b         = req.payload.rx_byte;
    assign crc_upd   = crc_step(crc_reg, b);
    assign crc_fin   = crc_step(crc_reg, extra);
    assign count_inc = {1'b0, count_reg} + 9'd1;

    mvr_extra_table u_extra_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept && (req.payload.req_type == REQ_TABLE_WR)),
        .wr_addr (req.payload.table_index),
        .wr_data (b),
        .rd_addr (msgid_reg),
        .rd_data (extra)
    );

    always_comb
    begin
        phase_next       = phase_reg;
        count_next       = count_reg;
        len_next         = len_reg;
        seq_next         = seq_reg;
        sys_next         = sys_reg;
        comp_next        = comp_reg;
        msgid_next       = msgid_reg;
        crc_next         = crc_reg;
        crc_low_next     = crc_low_reg;
        res_payload_next = '0;
        if (is_rx)
        begin
            case (phase_reg)
                PH_SEARCH:
                begin
                    if (b == start_byte_reg)
                    begin
                        phase_next = PH_HEADER;
                        count_next = '0;
                        crc_next   = CRC_INIT;
                    end
                end
                PH_HEADER:
                begin
                    case (count_reg)
                        8'd0:    len_next   = b;
                        8'd1:    seq_next   = b;
                        8'd2:    sys_next   = b;
                        8'd3:    comp_next  = b;
                        default: msgid_next = b;
                    endcase
                    crc_next   = crc_upd;
                    count_next = count_inc[7:0];
                    if (count_inc >= 9'(HDR_BYTES))
                    begin
                        count_next = '0;
                        phase_next = (len_reg != 8'd0) ? PH_PAYLOAD : PH_CRC;
                    end
                end
                PH_PAYLOAD:
                begin
                    res_payload_next.payload_valid = 1'b1;
                    res_payload_next.payload_byte  = b;
                    res_payload_next.payload_index = count_reg;
                    crc_next   = crc_upd;
                    count_next = count_inc[7:0];
                    if (count_inc >= {1'b0, len_reg})
                    begin
                        count_next = '0;
                        phase_next = PH_CRC;
                    end
                end
                PH_CRC:
                begin
                    if (count_reg == 8'd0)
                    begin
                        crc_low_next = b;
                        count_next   = 8'd1;
                    end
                    else
                    begin
                        res_payload_next.frame_done = 1'b1;
                        res_payload_next.crc_ok     = ({b, crc_low_reg} == crc_fin);
                        count_next = '0;
                        phase_next = PH_SEARCH;
                    end
                end
                default:
                begin
                    phase_next = PH_SEARCH;
                    count_next = '0;
                end
            endcase
        end
        res_payload_next.msg_length  = len_next;
        res_payload_next.msg_seq     = seq_next;
        res_payload_next.msg_sys_id  = sys_next;
        res_payload_next.msg_comp_id = comp_next;
        res_payload_next.msg_id      = msgid_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg <= START_BYTE_RESET;
            phase_reg      <= PH_SEARCH;
            count_reg      <= '0;
            len_reg        <= '0;
            seq_reg        <= '0;
            sys_reg        <= '0;
            comp_reg       <= '0;
            msgid_reg      <= '0;
            crc_reg        <= CRC_INIT;
            crc_low_reg    <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                start_byte_reg <= cfg.payload;
            end
            if (accept)
            begin
                phase_reg   <= phase_next;
                count_reg   <= count_next;
                len_reg     <= len_next;
                seq_reg     <= seq_next;
                sys_reg     <= sys_next;
                comp_reg    <= comp_next;
                msgid_reg   <= msgid_next;
                crc_reg     <= crc_next;
                crc_low_reg <= crc_low_next;
            end
            if (accept)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_payload_reg <= res_payload_next;
        end
    end

    assign res.valid   = res_valid_reg;
    assign res.payload = res_payload_reg;

`include "mavlink_v1_frame_receiver_assert.svh"

    `MVR_ASSERT_IMPLIES(a_done_returns_to_search, clk, rst_n,
        res_valid_reg && res_payload_reg.frame_done, phase_reg == PH_SEARCH,
        "frame reported done while the parser is still inside a frame")
    `MVR_ASSERT_IMPLIES(a_index_within_length, clk, rst_n,
        res_valid_reg && res_payload_reg.payload_valid,
        res_payload_reg.payload_index < res_payload_reg.msg_length,
        "payload index outside the header length")
    `MVR_ASSERT_NEVER(a_ok_without_done, clk, rst_n,
        res_valid_reg && res_payload_reg.crc_ok && !res_payload_reg.frame_done,
        "crc_ok reported without frame_done")
    `MVR_ASSERT_NEXT(a_header_advances, clk, rst_n,
        accept && is_rx && (phase_reg == PH_HEADER) && (count_reg < 8'd4),
        phase_reg == PH_HEADER,
        "header phase left before all header bytes were taken")

endmodule

`default_nettype wire

// ===== tb/mavlink_v1_frame_receiver_test.sv =====
// ============================================================================
// MAVLink v1 frame receiver testbench
// Sends serial bytes and CRC extra table writes through the request channel,
// mirrors the parser and the X.25 check in a local model, and compares every
// output word field by field. Directed frames come first, then random traffic
// with back-pressure, start byte changes and a gap-free tail.
// ============================================================================
`timescale 1ns / 1ps

module mavlink_v1_frame_receiver_test;

    import mvr_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;

    logic clk;
    logic rst_n;

    mvr_stream_if #(.payload_t(req_payload_t)) req_if ();
    mvr_stream_if #(.payload_t(res_payload_t)) res_if ();
    mvr_stream_if #(.payload_t(cfg_payload_t)) cfg_if ();

    mavlink_v1_frame_receiver i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .res   (res_if),
        .cfg   (cfg_if)
    );

    // Local copy of the parser state.
    phase_t      cur_phase;
    logic [8:0]  byte_cnt;
    logic [7:0]  hdr_len;
    logic [7:0]  hdr_seq;
    logic [7:0]  hdr_sys;
    logic [7:0]  hdr_comp;
    logic [7:0]  hdr_id;
    logic [15:0] crc_acc;
    logic [7:0]  crc_lo;
    logic [7:0]  extra_tbl [256];
    logic [7:0]  start_marker;

    res_payload_t parser_outputs_q [$];

    bit          traffic_gaps;
    int unsigned hold_left;
    int unsigned cycle_count;
    int unsigned requests_sent;
    int unsigned outputs_checked;
    int unsigned mismatches;
    int unsigned frames_passed;
    int unsigned frames_failed;
    int unsigned payload_seen;
    int unsigned cfg_writes;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic [15:0] x25_accumulate(input logic [15:0] crc,
                                                   input logic [7:0] data);
        logic [15:0] acc;
        int n;
        acc = crc ^ {8'h00, data};
        for (n = 0; n < 8; n++)
        begin
            if (acc[0])
                acc = (acc >> 1) ^ 16'h8408;
            else
                acc = acc >> 1;
        end
        return acc;
    endfunction

    function automatic res_payload_t parser_step(input req_payload_t item);
        res_payload_t out;
        logic [7:0] b;
        out = '0;
        b = item.rx_byte;
        if (item.req_type == REQ_TABLE_WR)
        begin
            extra_tbl[item.table_index] = b;
        end
        else
        begin
            case (cur_phase)
                PH_SEARCH:
                begin
                    if (b == start_marker)
                    begin
                        cur_phase = PH_HEADER;
                        byte_cnt = '0;
                        crc_acc = CRC_INIT;
                    end
                end
                PH_HEADER:
                begin
                    case (byte_cnt)
                        9'd0: hdr_len = b;
                        9'd1: hdr_seq = b;
                        9'd2: hdr_sys = b;
                        9'd3: hdr_comp = b;
                        default: hdr_id = b;
                    endcase
                    crc_acc = x25_accumulate(crc_acc, b);
                    byte_cnt = byte_cnt + 9'd1;
                    if (byte_cnt >= HDR_BYTES)
                    begin
                        byte_cnt = '0;
                        if (hdr_len != 8'd0)
                            cur_phase = PH_PAYLOAD;
                        else
                            cur_phase = PH_CRC;
                    end
                end
                PH_PAYLOAD:
                begin
                    out.payload_valid = 1'b1;
                    out.payload_byte = b;
                    out.payload_index = byte_cnt[7:0];
                    crc_acc = x25_accumulate(crc_acc, b);
                    byte_cnt = byte_cnt + 9'd1;
                    if (byte_cnt >= {1'b0, hdr_len})
                    begin
                        byte_cnt = '0;
                        cur_phase = PH_CRC;
                    end
                end
                default:
                begin
                    if (byte_cnt == 9'd0)
                    begin
                        crc_lo = b;
                        byte_cnt = 9'd1;
                    end
                    else
                    begin
                        out.frame_done = 1'b1;
                        out.crc_ok = ({b, crc_lo}
                                      == x25_accumulate(crc_acc, extra_tbl[hdr_id]));
                        byte_cnt = '0;
                        cur_phase = PH_SEARCH;
                    end
                end
            endcase
        end
        out.msg_length = hdr_len;
        out.msg_seq = hdr_seq;
        out.msg_sys_id = hdr_sys;
        out.msg_comp_id = hdr_comp;
        out.msg_id = hdr_id;
        return out;
    endfunction

    function automatic string describe(input res_payload_t s);
        return $sformatf("pv=%0b pb=%02h pi=%0d done=%0b ok=%0b hdr=%02h/%02h/%02h/%02h/%02h",
                         s.payload_valid, s.payload_byte, s.payload_index, s.frame_done,
                         s.crc_ok, s.msg_length, s.msg_seq, s.msg_sys_id, s.msg_comp_id,
                         s.msg_id);
    endfunction

    task automatic send_request(input logic kind, input logic [7:0] data,
                                input logic [7:0] index);
        req_payload_t item;
        int unsigned pause;
        item.req_type = kind;
        item.rx_byte = data;
        item.table_index = index;
        if (traffic_gaps && $urandom_range(0, 5) == 0)
        begin
            pause = $urandom_range(1, 13);
            req_if.valid <= 1'b0;
            repeat (pause) @(posedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.payload <= item;
        do @(posedge clk); while (!req_if.ready);
        parser_outputs_q.push_back(parser_step(item));
        requests_sent++;
    endtask

    task automatic send_idle_byte();
        logic [7:0] b;
        do b = 8'($urandom); while (b == start_marker);
        send_request(REQ_RX_BYTE, b, 8'($urandom));
    endtask

    task automatic send_frame(input logic [7:0] len, input logic [7:0] seq,
                              input logic [7:0] sys, input logic [7:0] comp,
                              input logic [7:0] id, input int fill, input bit corrupt,
                              input bit mid_write);
        logic [7:0] hdr [5];
        logic [7:0] body;
        logic [15:0] crc;
        int k;
        hdr = '{len, seq, sys, comp, id};
        crc = CRC_INIT;
        send_request(REQ_RX_BYTE, start_marker, 8'($urandom));
        for (k = 0; k < 5; k++)
        begin
            crc = x25_accumulate(crc, hdr[k]);
            send_request(REQ_RX_BYTE, hdr[k], 8'($urandom));
        end
        if (mid_write)
            send_request(REQ_TABLE_WR, 8'($urandom), id);
        for (k = 0; k < int'(len); k++)
        begin
            if (fill < 0)
                body = 8'($urandom);
            else
                body = fill[7:0];
            crc = x25_accumulate(crc, body);
            send_request(REQ_RX_BYTE, body, 8'($urandom));
        end
        crc = x25_accumulate(crc, extra_tbl[id]);
        if (corrupt)
            crc = crc ^ (16'h0001 << $urandom_range(0, 15));
        send_request(REQ_RX_BYTE, crc[7:0], 8'($urandom));
        send_request(REQ_RX_BYTE, crc[15:8], 8'($urandom));
    endtask

    task automatic send_random_frame(input int unsigned len);
        logic [7:0] id;
        if ($urandom_range(0, 1) == 0)
            id = 8'($urandom_range(0, 15));
        else
            id = 8'($urandom);
        send_frame(8'(len), 8'($urandom), 8'($urandom), 8'($urandom), id, -1,
                   $urandom_range(0, 4) == 0, $urandom_range(0, 9) == 0);
    endtask

    task automatic drain_results();
        req_if.valid <= 1'b0;
        while (parser_outputs_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_start_byte(input logic [7:0] value);
        drain_results();
        cfg_if.valid <= 1'b1;
        cfg_if.payload <= value;
        do @(posedge clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        start_marker = value;
        cfg_writes++;
    endtask

    task automatic test_table_and_idle();
        send_request(REQ_TABLE_WR, 8'hFF, 8'h00);
        send_request(REQ_TABLE_WR, 8'h81, 8'hFF);
        send_request(REQ_RX_BYTE, 8'h00, 8'hFF);
        send_request(REQ_RX_BYTE, 8'hFF, 8'h00);
    endtask

    task automatic test_zero_length();
        send_frame(8'd0, 8'h00, 8'hFF, 8'h00, 8'hFF, -1, 1'b0, 1'b0);
    endtask

    task automatic test_start_in_payload();
        send_frame(8'd2, 8'hFF, 8'h00, 8'hFF, 8'h00, int'(start_marker), 1'b0, 1'b1);
    endtask

    task automatic test_crc_failure();
        send_frame(8'd0, 8'h01, 8'h01, 8'h01, 8'h00, -1, 1'b1, 1'b0);
    endtask

    task automatic test_start_byte_config();
        logic [7:0] settings [4];
        int s;
        settings = '{8'h00, 8'hFF, 8'h3C, START_BYTE_RESET};
        for (s = 0; s < 4; s++)
        begin
            write_start_byte(settings[s]);
            send_idle_byte();
            send_random_frame($urandom_range(0, 6));
            send_frame(8'($urandom_range(1, 4)), 8'($urandom), 8'($urandom),
                       8'($urandom), 8'($urandom), -1, 1'b1, 1'b0);
        end
        drain_results();
    endtask

    task automatic test_backpressure();
        traffic_gaps = 1'b0;
        hold_left = 150;
        repeat (3)
            send_frame(8'd8, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), -1,
                       1'b0, 1'b0);
        drain_results();
        traffic_gaps = 1'b1;
        hold_left = 60;
        send_random_frame(20);
        drain_results();
    endtask

    task automatic test_random_traffic(input int unsigned budget);
        int unsigned spent;
        int unsigned pick;
        int unsigned len;
        int unsigned k;
        int unsigned n;
        spent = 0;
        send_random_frame(255);
        spent += 263;
        while (spent < budget)
        begin
            traffic_gaps = ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 99);
            if (pick < 62)
            begin
                k = $urandom_range(0, 99);
                if (k < 88)
                    len = $urandom_range(0, 12);
                else if (k < 98)
                    len = $urandom_range(13, 60);
                else
                    len = $urandom_range(61, 255);
                send_random_frame(len);
                spent += len + 8;
            end
            else if (pick < 77)
            begin
                if ($urandom_range(0, 1) == 0)
                    send_request(REQ_TABLE_WR, 8'($urandom), 8'($urandom_range(0, 15)));
                else
                    send_request(REQ_TABLE_WR, 8'($urandom), 8'($urandom));
                spent++;
            end
            else if (pick < 90)
            begin
                n = $urandom_range(1, 4);
                for (k = 0; k < n; k++)
                    send_idle_byte();
            end
            else
            begin
                // A truncated or garbled frame, then filler until the parser hunts again.
                send_request(REQ_RX_BYTE, start_marker, 8'($urandom));
                send_request(REQ_RX_BYTE, 8'($urandom_range(0, 20)), 8'($urandom));
                spent += 2;
                n = $urandom_range(0, 8);
                for (k = 0; k < n; k++)
                begin
                    send_request(REQ_RX_BYTE, 8'($urandom), 8'($urandom));
                    spent++;
                end
                while (cur_phase != PH_SEARCH)
                begin
                    send_request(REQ_RX_BYTE, 8'($urandom), 8'($urandom));
                    spent++;
                end
            end
        end
        drain_results();
    endtask

    task automatic test_steady_tail();
        int k;
        traffic_gaps = 1'b0;
        for (k = 0; k < 4; k++)
            send_random_frame($urandom_range(0, 12));
        drain_results();
    endtask

    initial
    begin
        int k;
        rst_n = 1'b0;
        req_if.valid = 1'b0;
        req_if.payload = '0;
        cfg_if.valid = 1'b0;
        cfg_if.payload = '0;
        cur_phase = PH_SEARCH;
        byte_cnt = '0;
        hdr_len = '0;
        hdr_seq = '0;
        hdr_sys = '0;
        hdr_comp = '0;
        hdr_id = '0;
        crc_acc = CRC_INIT;
        crc_lo = '0;
        for (k = 0; k < 256; k++)
            extra_tbl[k] = '0;
        start_marker = START_BYTE_RESET;
        traffic_gaps = 1'b1;
        hold_left = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_table_and_idle();
        test_zero_length();
        test_start_in_payload();
        test_crc_failure();
        drain_results();
        test_start_byte_config();
        test_backpressure();
        test_random_traffic(950);
        test_steady_tail();

        $display("Covered %0d requests and %0d start byte writes: %0d frames passed CRC,",
                 requests_sent, cfg_writes, frames_passed);
        $display("%0d frames failed CRC, %0d payload bytes, %0d outputs checked, %0d mismatches.",
                 frames_failed, payload_seen, outputs_checked, mismatches);
        if (mismatches == 0 && parser_outputs_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        int unsigned stall_left;
        stall_left = 0;
        res_if.ready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                res_if.ready <= 1'b0;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                res_if.ready <= 1'b0;
                stall_left--;
            end
            else if (traffic_gaps && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(0, 12);
                res_if.ready <= 1'b0;
            end
            else
            begin
                res_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin : check_outputs
        res_payload_t want;
        res_payload_t got;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            got = res_if.payload;
            outputs_checked++;
            if (parser_outputs_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected output %0d with nothing pending: %s",
                             outputs_checked, describe(got));
            end
            else
            begin
                want = parser_outputs_q.pop_front();
                if (got.payload_valid !== want.payload_valid
                    || got.payload_byte !== want.payload_byte
                    || got.payload_index !== want.payload_index
                    || got.frame_done !== want.frame_done
                    || got.crc_ok !== want.crc_ok
                    || got.msg_length !== want.msg_length
                    || got.msg_seq !== want.msg_seq
                    || got.msg_sys_id !== want.msg_sys_id
                    || got.msg_comp_id !== want.msg_comp_id
                    || got.msg_id !== want.msg_id)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch on output %0d: expected %s, actual %s",
                                 outputs_checked, describe(want), describe(got));
                end
                if (want.frame_done && want.crc_ok)
                    frames_passed++;
                else if (want.frame_done)
                    frames_failed++;
                if (want.payload_valid)
                    payload_seen++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d outputs pending.",
                     cycle_count, parser_outputs_q.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/mvr_pkg.sv
rtl/mvr_stream_if.sv
rtl/mvr_extra_table.sv
rtl/mavlink_v1_frame_receiver.sv
tb/mavlink_v1_frame_receiver_test.sv
